// ===== rtl/rwct_pkg.sv =====
// Package for the raycast wall column texturer: sizes, request codes, types.
// No dependencies.
package rwct_pkg;
	localparam int TILE = 64;
	localparam int SCREEN_ROWS = 720;
	localparam int TILE_W = $clog2(TILE);
	localparam int TEX_W = 2;
	localparam int ADDR_W = TEX_W + 2 * TILE_W;
	localparam int DEPTH = 4 * TILE * TILE;
	localparam int SPAN_W = 16;
	localparam logic [SPAN_W-1:0] SPAN_MAX = '1;
	localparam int ROW_W = 11;
	localparam int POS_W = 17;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
	localparam logic signed [POS_W-1:0] MID = POS_W'(SCREEN_ROWS / 2);
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_EMIT = 2'd2;
	localparam logic [1:0] CFG_PROJ = 2'd0;
	localparam logic [1:0] CFG_CEIL = 2'd1;
	localparam logic [1:0] CFG_FLOOR = 2'd2;
	localparam logic [1:0] TEX_NORTH = 2'd0;
	localparam logic [1:0] TEX_SOUTH = 2'd1;
	localparam logic [1:0] TEX_EAST = 2'd2;
	localparam logic [1:0] TEX_WEST = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] texture_id;
		logic [11:0] texel_index;
		logic [31:0] texel_value;
		logic [11:0] column;
		logic is_vertical;
		logic [15:0] ray_angle;
		logic [15:0] hit_x;
		logic [15:0] hit_y;
		logic [23:0] distance;
	} req_t;

	typedef struct packed {
		logic [11:0] out_column;
		logic [10:0] out_row;
		logic [31:0] pixel_color;
		logic last_of_column;
	} pix_t;

	typedef struct packed {
		logic [1:0] index;
		logic [31:0] data;
	} cfg_t;
endpackage

// ===== rtl/rwct_if.sv =====
// Valid/ready channel interfaces carrying rwct_pkg payload types.
// Depends on rwct_pkg.
interface rwct_req_if;
	logic valid;
	logic ready;
	rwct_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rwct_pix_if;
	logic valid;
	logic ready;
	rwct_pkg::pix_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rwct_cfg_if;
	logic valid;
	logic ready;
	rwct_pkg::cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/rwct_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rwct_pkg.
module rwct_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [23:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import rwct_pkg::*;
	logic [23:0] rem_q;
	logic [31:0] quo_q;
	logic [23:0] div_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [24:0] trial;
	logic fits;
	logic [23:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign fits = trial >= {1'b0, div_q};
	assign diff = trial[23:0] - div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[23:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// ===== rtl/rwct_texel_ram.sv =====
// Texel store: single-port synchronous RAM with registered read data.
// Depends on rwct_pkg.
module rwct_texel_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [rwct_pkg::ADDR_W-1:0] addr,
	input  logic [31:0]                wdata,
	output logic [31:0]                rdata
);
	import rwct_pkg::*;
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		if (re) rdata <= mem[addr];
	end
endmodule

// ===== rtl/raycast_wall_column_texturer.sv =====
// Top level: sequencer for texel writes, column setup and pixel emission.
// Texel writes go to the RAM on accept; column start runs the 32-step divider for the span,
// unless distance is zero (span set to maximum); a wall pixel needs a row divide and RAM read.
// One item at a time; input also waits while the result register holds an unaccepted pixel.
// Asynchronous active-low reset clears column state and registers to reset values;
// texel memory is undefined until written.
module raycast_wall_column_texturer (
	input  logic clk,
	input  logic arst_n,
	rwct_req_if.sink   req,
	rwct_cfg_if.sink   cfg,
	rwct_pix_if.source pix
);
	import rwct_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SPAN, ST_ROW, ST_READ, ST_OUT
	} state_t;
	state_t state_q;

	logic [23:0] proj_q;
	logic [31:0] ceil_q, floor_q;
	logic [11:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic signed [POS_W-1:0] top_q, bot_q;
	logic [SPAN_W-1:0] span_q;
	logic [1:0] tex_q;
	logic [TILE_W-1:0] tcol_q;
	logic [TILE_W-1:0] trow_q;
	pix_t res_q;
	logic busy_q;

	logic div_start, div_done;
	logic [31:0] div_a, div_q;
	logic [23:0] div_b;
	logic ram_we, ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [31:0] ram_rdata;
	logic signed [POS_W-1:0] y;
	logic accept;
	logic can_out;
	logic [1:0] tex_pick;
	logic last;

	assign can_out = !pix.valid || pix.ready;
	assign req.ready = (state_q == ST_IDLE) && can_out;
	assign cfg.ready = 1'b1;
	assign accept = req.valid && req.ready;
	assign y = POS_W'(row_q);
	assign last = row_q >= LAST_ROW;

	always_comb begin
		if (req.data.is_vertical)
			tex_pick = (req.data.ray_angle > 16'd16384 && req.data.ray_angle < 16'd49152)
				? TEX_WEST : TEX_EAST;
		else
			tex_pick = (req.data.ray_angle != 16'd0 && !req.data.ray_angle[15])
				? TEX_NORTH : TEX_SOUTH;
	end

	always_comb begin
		div_start = 1'b0;
		div_a = 32'(proj_q) * 32'(TILE);
		div_b = req.data.distance;
		if (accept && req.data.req_type == REQ_START && req.data.distance != '0)
			div_start = 1'b1;
		if (state_q == ST_ROW && !busy_q) begin
			div_start = 1'b1;
			div_a = 32'(unsigned'(y - top_q)) * 32'(TILE);
			div_b = 24'(span_q);
		end
	end

	rwct_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
	);

	assign ram_we = accept && req.data.req_type == REQ_WRITE
		&& {1'b0, req.data.texel_index} < 13'(TILE * TILE);
	assign ram_re = state_q == ST_READ;
	assign ram_addr = ram_we
		? {req.data.texture_id, req.data.texel_index[2*TILE_W-1:0]}
		: {tex_q, trow_q, tcol_q};

	rwct_texel_ram u_ram (
		.clk(clk), .we(ram_we), .re(ram_re), .addr(ram_addr),
		.wdata(req.data.texel_value), .rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			proj_q <= 24'd227021;
			ceil_q <= '0;
			floor_q <= '0;
			col_q <= '0;
			row_q <= '0;
			top_q <= '0;
			bot_q <= '0;
			span_q <= '0;
			tex_q <= '0;
			tcol_q <= '0;
			trow_q <= '0;
			pix.valid <= 1'b0;
			res_q <= '0;
		end else begin
			if (state_q == ST_OUT && can_out) pix.valid <= 1'b1;
			else if (pix.ready) pix.valid <= 1'b0;
			if (cfg.valid) begin
				case (cfg.data.index)
					CFG_PROJ: proj_q <= cfg.data.data[23:0];
					CFG_CEIL: ceil_q <= cfg.data.data;
					CFG_FLOOR: floor_q <= cfg.data.data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && req.data.req_type == REQ_START) begin
						col_q <= req.data.column;
						row_q <= '0;
						tex_q <= tex_pick;
						tcol_q <= req.data.is_vertical ? req.data.hit_y[TILE_W-1:0]
							: req.data.hit_x[TILE_W-1:0];
						if (req.data.distance == '0) begin
							span_q <= SPAN_MAX;
							top_q <= MID - POS_W'(SPAN_MAX >> 1);
							bot_q <= MID + POS_W'(SPAN_MAX >> 1);
						end else begin
							state_q <= ST_SPAN;
						end
					end else if (accept && req.data.req_type == REQ_EMIT) begin
						res_q.out_column <= col_q;
						res_q.out_row <= row_q;
						res_q.last_of_column <= last;
						if (y < top_q) begin
							res_q.pixel_color <= ceil_q;
							state_q <= ST_OUT;
						end else if (y < bot_q) begin
							state_q <= ST_ROW;
						end else begin
							res_q.pixel_color <= floor_q;
							state_q <= ST_OUT;
						end
					end
				end
				ST_SPAN: begin
					if (div_done) begin
						span_q <= (div_q > 32'(SPAN_MAX)) ? SPAN_MAX : div_q[SPAN_W-1:0];
						top_q <= MID - POS_W'(((div_q > 32'(SPAN_MAX)) ? SPAN_MAX
							: div_q[SPAN_W-1:0]) >> 1);
						bot_q <= MID + POS_W'(((div_q > 32'(SPAN_MAX)) ? SPAN_MAX
							: div_q[SPAN_W-1:0]) >> 1);
						state_q <= ST_IDLE;
					end
				end
				ST_ROW: begin
					if (!busy_q) busy_q <= 1'b1;
					else if (div_done) begin
						busy_q <= 1'b0;
						trow_q <= (div_q > 32'(TILE - 1)) ? TILE_W'(TILE - 1)
							: div_q[TILE_W-1:0];
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (busy_q) begin
						busy_q <= 1'b0;
						res_q.pixel_color <= ram_rdata;
						state_q <= ST_OUT;
					end else begin
						busy_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (can_out) begin
						row_q <= last ? '0 : row_q + ROW_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pix.data = res_q;
endmodule
